// ===== rtl/pmsm_pkg.sv =====
package pmsm_pkg;

  // Fixed field widths
  localparam int unsigned AddrW = 32;
  localparam int unsigned KindW = 32;

  // Request modes
  localparam logic [1:0] MODE_ADD   = 2'd0;
  localparam logic [1:0] MODE_SET   = 2'd1;
  localparam logic [1:0] MODE_ALLOC = 2'd2;
  localparam logic [1:0] MODE_READ  = 2'd3;

  // Result status codes
  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_MISS = 2'd1;
  localparam logic [1:0] STAT_FULL = 2'd2;
  localparam logic [1:0] STAT_BAD  = 2'd3;

  // One table entry
  typedef struct packed {
    logic [AddrW-1:0] base;
    logic [AddrW-1:0] len;
    logic [KindW-1:0] kind;
  } seg_t;

  // Datapath micro-operations
  typedef enum logic [5:0] {
    OP_NOP,
    OP_LOAD,
    OP_RES_ST,
    OP_ADD_INIT,
    OP_RD_PTR,
    OP_PTR_INC,
    OP_ADD_POS,
    OP_SET_INIT,
    OP_SR_ST,
    OP_SR_ROUND,
    OP_SR_END,
    OP_LD_ENT,
    OP_SR_FULL,
    OP_SR_PART,
    OP_SR_ADV,
    OP_RT_WHOLE,
    OP_RT_HEAD,
    OP_RT_TAIL,
    OP_RT_MID,
    OP_RT_MID2,
    OP_POS_DEC,
    OP_INS_INIT,
    OP_RD_PTRM1,
    OP_MV_UP,
    OP_INS_WR,
    OP_RD_POS,
    OP_LD_M,
    OP_RD_POSM1,
    OP_MRG_LW,
    OP_RD_POSP1,
    OP_MRG_RW,
    OP_ERS_MV,
    OP_CNT_DEC,
    OP_AL_INIT,
    OP_AL_RD,
    OP_AL_GO,
    OP_AL_OK,
    OP_FIN_SET,
    OP_EMIT,
    OP_RD_EIDX,
    OP_RD_OUT
  } op_e;

  // Controller to datapath
  typedef struct packed {
    op_e        op;
    logic [1:0] code;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [1:0] mode;
    logic       full;
    logic       full2;
    logic       cnt_zero;
    logic       al_bad;
    logic       eidx_ok;
    logic       ptr_eq_cnt;
    logic       ptr_eq_pos;
    logic       rd_gt_a;
    logic       al_hit;
    logic       aidx_zero;
    logic       pass_over;
    logic       sc_full;
    logic       sc_part;
    logic       rt_whole;
    logic       rt_head;
    logic       rt_tail;
    logic       kind_diff;
    logic       pos_ge_cnt;
    logic       pos_zero;
    logic       pos1_ge_cnt;
    logic       rdk_eq_mk;
    logic [1:0] sr_st;
  } sts_t;

endpackage

// ===== rtl/pmsm_ctrl.sv =====
module pmsm_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  pmsm_pkg::sts_t sts_i,
  output pmsm_pkg::cmd_t cmd_o,
  output logic          busy_o
);
  import pmsm_pkg::*;

  localparam logic [5:0] ST_IDLE      = 6'd0;
  localparam logic [5:0] ST_DISP      = 6'd1;
  localparam logic [5:0] ST_ADD_RD    = 6'd2;
  localparam logic [5:0] ST_ADD_CHK   = 6'd3;
  localparam logic [5:0] ST_ADD_MRG   = 6'd4;
  localparam logic [5:0] ST_SR_PASS   = 6'd5;
  localparam logic [5:0] ST_SR_END    = 6'd6;
  localparam logic [5:0] ST_SR_RD     = 6'd7;
  localparam logic [5:0] ST_SR_E      = 6'd8;
  localparam logic [5:0] ST_SR_CHK    = 6'd9;
  localparam logic [5:0] ST_RT_START  = 6'd10;
  localparam logic [5:0] ST_RT_MRG    = 6'd11;
  localparam logic [5:0] ST_RT_MID2   = 6'd12;
  localparam logic [5:0] ST_RT_MID3   = 6'd13;
  localparam logic [5:0] ST_RT_DONE   = 6'd14;
  localparam logic [5:0] ST_INS_START = 6'd15;
  localparam logic [5:0] ST_INS_LOOP  = 6'd16;
  localparam logic [5:0] ST_INS_MV    = 6'd17;
  localparam logic [5:0] ST_ERS_LOOP  = 6'd18;
  localparam logic [5:0] ST_ERS_MV    = 6'd19;
  localparam logic [5:0] ST_MRG_START = 6'd20;
  localparam logic [5:0] ST_MRG_LD    = 6'd21;
  localparam logic [5:0] ST_MRG_L     = 6'd22;
  localparam logic [5:0] ST_MRG_LC    = 6'd23;
  localparam logic [5:0] ST_MRG_R     = 6'd24;
  localparam logic [5:0] ST_MRG_RC    = 6'd25;
  localparam logic [5:0] ST_MRG_END   = 6'd26;
  localparam logic [5:0] ST_SET_FIN   = 6'd27;
  localparam logic [5:0] ST_AL_NEXT   = 6'd28;
  localparam logic [5:0] ST_AL_CHK    = 6'd29;
  localparam logic [5:0] ST_AL_RES    = 6'd30;
  localparam logic [5:0] ST_RD_OUT    = 6'd31;
  localparam logic [5:0] ST_DONE      = 6'd32;

  logic [5:0] state_q, state_d;
  logic [5:0] ins_ret_q, ins_ret_d;
  logic [5:0] mrg_ret_q, mrg_ret_d;
  logic [5:0] ers_ret_q, ers_ret_d;
  logic [5:0] set_ret_q, set_ret_d;
  logic       rt_final_q, rt_final_d;

  assign busy_o = (state_q != ST_IDLE);

  // Sequence micro-operations; subroutines return through saved states
  always_comb begin
    state_d    = state_q;
    ins_ret_d  = ins_ret_q;
    mrg_ret_d  = mrg_ret_q;
    ers_ret_d  = ers_ret_q;
    set_ret_d  = set_ret_q;
    rt_final_d = rt_final_q;
    cmd_o.op   = OP_NOP;
    cmd_o.code = STAT_OK;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = ST_DISP;
        end
      end
      ST_DISP: begin
        unique case (sts_i.mode)
          MODE_ADD: begin
            if (sts_i.full) begin
              cmd_o.op   = OP_RES_ST;
              cmd_o.code = STAT_FULL;
              state_d    = ST_DONE;
            end else begin
              cmd_o.op = OP_ADD_INIT;
              state_d  = ST_ADD_RD;
            end
          end
          MODE_SET: begin
            cmd_o.op  = OP_SET_INIT;
            set_ret_d = ST_SET_FIN;
            state_d   = ST_SR_PASS;
          end
          MODE_ALLOC: begin
            if (sts_i.al_bad) begin
              cmd_o.op   = OP_RES_ST;
              cmd_o.code = STAT_BAD;
              state_d    = ST_DONE;
            end else if (sts_i.cnt_zero) begin
              cmd_o.op   = OP_RES_ST;
              cmd_o.code = STAT_MISS;
              state_d    = ST_DONE;
            end else begin
              cmd_o.op = OP_AL_INIT;
              state_d  = ST_AL_NEXT;
            end
          end
          MODE_READ: begin
            if (sts_i.eidx_ok) begin
              cmd_o.op = OP_RD_EIDX;
              state_d  = ST_RD_OUT;
            end else begin
              cmd_o.op   = OP_RES_ST;
              cmd_o.code = STAT_BAD;
              state_d    = ST_DONE;
            end
          end
          default: state_d = ST_DONE;
        endcase
      end
      // Add: find first entry with larger base
      ST_ADD_RD: begin
        if (sts_i.ptr_eq_cnt) begin
          cmd_o.op  = OP_ADD_POS;
          ins_ret_d = ST_ADD_MRG;
          state_d   = ST_INS_START;
        end else begin
          cmd_o.op = OP_RD_PTR;
          state_d  = ST_ADD_CHK;
        end
      end
      ST_ADD_CHK: begin
        if (sts_i.rd_gt_a) begin
          cmd_o.op  = OP_ADD_POS;
          ins_ret_d = ST_ADD_MRG;
          state_d   = ST_INS_START;
        end else begin
          cmd_o.op = OP_PTR_INC;
          state_d  = ST_ADD_RD;
        end
      end
      ST_ADD_MRG: begin
        mrg_ret_d = ST_DONE;
        state_d   = ST_MRG_START;
      end
      // Set range: one pass per touched segment
      ST_SR_PASS: begin
        if (sts_i.pass_over) begin
          cmd_o.op   = OP_SR_ST;
          cmd_o.code = STAT_MISS;
          state_d    = set_ret_q;
        end else begin
          cmd_o.op = OP_SR_ROUND;
          state_d  = ST_SR_END;
        end
      end
      ST_SR_END: begin
        cmd_o.op = OP_SR_END;
        state_d  = ST_SR_RD;
      end
      ST_SR_RD: begin
        if (sts_i.ptr_eq_cnt) begin
          cmd_o.op   = OP_SR_ST;
          cmd_o.code = STAT_MISS;
          state_d    = set_ret_q;
        end else begin
          cmd_o.op = OP_RD_PTR;
          state_d  = ST_SR_E;
        end
      end
      ST_SR_E: begin
        cmd_o.op = OP_LD_ENT;
        state_d  = ST_SR_CHK;
      end
      ST_SR_CHK: begin
        priority if (sts_i.sc_full) begin
          cmd_o.op   = OP_SR_FULL;
          rt_final_d = 1'b1;
          state_d    = ST_RT_START;
        end else if (sts_i.sc_part) begin
          cmd_o.op   = OP_SR_PART;
          rt_final_d = 1'b0;
          state_d    = ST_RT_START;
        end else begin
          cmd_o.op = OP_PTR_INC;
          state_d  = ST_SR_RD;
        end
      end
      // Retype part of one segment
      ST_RT_START: begin
        priority if (sts_i.rt_whole) begin
          if (sts_i.kind_diff) begin
            cmd_o.op  = OP_RT_WHOLE;
            mrg_ret_d = ST_RT_DONE;
            state_d   = ST_MRG_START;
          end else begin
            cmd_o.op   = OP_SR_ST;
            cmd_o.code = STAT_OK;
            state_d    = ST_RT_DONE;
          end
        end else if (sts_i.rt_head || sts_i.rt_tail) begin
          if (sts_i.full) begin
            cmd_o.op   = OP_SR_ST;
            cmd_o.code = STAT_FULL;
            state_d    = ST_RT_DONE;
          end else begin
            cmd_o.op  = sts_i.rt_head ? OP_RT_HEAD : OP_RT_TAIL;
            ins_ret_d = ST_RT_MRG;
            state_d   = ST_INS_START;
          end
        end else begin
          if (sts_i.full2) begin
            cmd_o.op   = OP_SR_ST;
            cmd_o.code = STAT_FULL;
            state_d    = ST_RT_DONE;
          end else begin
            cmd_o.op  = OP_RT_MID;
            ins_ret_d = ST_RT_MID2;
            state_d   = ST_INS_START;
          end
        end
      end
      ST_RT_MRG: begin
        mrg_ret_d = ST_RT_DONE;
        state_d   = ST_MRG_START;
      end
      ST_RT_MID2: begin
        cmd_o.op  = OP_RT_MID2;
        ins_ret_d = ST_RT_MID3;
        state_d   = ST_INS_START;
      end
      ST_RT_MID3: begin
        cmd_o.op  = OP_POS_DEC;
        mrg_ret_d = ST_RT_DONE;
        state_d   = ST_MRG_START;
      end
      ST_RT_DONE: begin
        if (rt_final_q || (sts_i.sr_st != STAT_OK)) begin
          state_d = set_ret_q;
        end else begin
          cmd_o.op = OP_SR_ADV;
          state_d  = ST_SR_PASS;
        end
      end
      // Insert: shift entries up, then write the new one
      ST_INS_START: begin
        cmd_o.op = OP_INS_INIT;
        state_d  = ST_INS_LOOP;
      end
      ST_INS_LOOP: begin
        if (sts_i.ptr_eq_pos) begin
          cmd_o.op = OP_INS_WR;
          state_d  = ins_ret_q;
        end else begin
          cmd_o.op = OP_RD_PTRM1;
          state_d  = ST_INS_MV;
        end
      end
      ST_INS_MV: begin
        cmd_o.op = OP_MV_UP;
        state_d  = ST_INS_LOOP;
      end
      // Erase: shift entries down
      ST_ERS_LOOP: begin
        if (sts_i.ptr_eq_cnt) begin
          cmd_o.op = OP_CNT_DEC;
          state_d  = ers_ret_q;
        end else begin
          cmd_o.op = OP_RD_PTR;
          state_d  = ST_ERS_MV;
        end
      end
      ST_ERS_MV: begin
        cmd_o.op = OP_ERS_MV;
        state_d  = ST_ERS_LOOP;
      end
      // Merge with equal-type neighbors
      ST_MRG_START: begin
        if (sts_i.pos_ge_cnt) begin
          state_d = mrg_ret_q;
        end else begin
          cmd_o.op = OP_RD_POS;
          state_d  = ST_MRG_LD;
        end
      end
      ST_MRG_LD: begin
        cmd_o.op = OP_LD_M;
        state_d  = ST_MRG_L;
      end
      ST_MRG_L: begin
        if (sts_i.pos_zero) begin
          state_d = ST_MRG_R;
        end else begin
          cmd_o.op = OP_RD_POSM1;
          state_d  = ST_MRG_LC;
        end
      end
      ST_MRG_LC: begin
        if (sts_i.rdk_eq_mk) begin
          cmd_o.op  = OP_MRG_LW;
          ers_ret_d = ST_MRG_R;
          state_d   = ST_ERS_LOOP;
        end else begin
          state_d = ST_MRG_R;
        end
      end
      ST_MRG_R: begin
        if (sts_i.pos1_ge_cnt) begin
          state_d = mrg_ret_q;
        end else begin
          cmd_o.op = OP_RD_POSP1;
          state_d  = ST_MRG_RC;
        end
      end
      ST_MRG_RC: begin
        if (sts_i.rdk_eq_mk) begin
          cmd_o.op  = OP_MRG_RW;
          ers_ret_d = ST_MRG_END;
          state_d   = ST_ERS_LOOP;
        end else begin
          state_d = mrg_ret_q;
        end
      end
      ST_MRG_END: state_d = mrg_ret_q;
      ST_SET_FIN: begin
        cmd_o.op = OP_FIN_SET;
        state_d  = ST_DONE;
      end
      // Allocate: walk from the top entry down
      ST_AL_NEXT: begin
        if (sts_i.aidx_zero) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.op = OP_AL_RD;
          state_d  = ST_AL_CHK;
        end
      end
      ST_AL_CHK: begin
        if (sts_i.al_hit) begin
          cmd_o.op  = OP_AL_GO;
          set_ret_d = ST_AL_RES;
          state_d   = ST_SR_PASS;
        end else begin
          state_d = ST_AL_NEXT;
        end
      end
      ST_AL_RES: begin
        priority if (sts_i.sr_st == STAT_MISS) begin
          state_d = ST_AL_NEXT;
        end else if (sts_i.sr_st == STAT_OK) begin
          cmd_o.op = OP_AL_OK;
          state_d  = ST_DONE;
        end else begin
          cmd_o.op   = OP_RES_ST;
          cmd_o.code = STAT_FULL;
          state_d    = ST_DONE;
        end
      end
      ST_RD_OUT: begin
        cmd_o.op = OP_RD_OUT;
        state_d  = ST_DONE;
      end
      ST_DONE: begin
        cmd_o.op = OP_EMIT;
        state_d  = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      ins_ret_q  <= ST_IDLE;
      mrg_ret_q  <= ST_IDLE;
      ers_ret_q  <= ST_IDLE;
      set_ret_q  <= ST_IDLE;
      rt_final_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      ins_ret_q  <= ins_ret_d;
      mrg_ret_q  <= mrg_ret_d;
      ers_ret_q  <= ers_ret_d;
      set_ret_q  <= set_ret_d;
      rt_final_q <= rt_final_d;
    end
  end

endmodule

// ===== rtl/pmsm_dp.sv =====
module pmsm_dp #(
  parameter int unsigned MaxSegments = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  pmsm_pkg::cmd_t cmd_i,
  output pmsm_pkg::sts_t sts_o,
  input  logic           cfg_valid_i,
  input  logic [4:0]     cfg_data_i,
  input  logic [1:0]     mode_i,
  input  logic [31:0]    address_i,
  input  logic [31:0]    size_i,
  input  logic [31:0]    type_code_i,
  input  logic [31:0]    from_type_i,
  input  logic [31:0]    alloc_align_i,
  input  logic [5:0]     entry_index_i,
  output logic           valid_o,
  output logic [1:0]     status_o,
  output logic [31:0]    alloc_address_o,
  output logic [31:0]    entry_base_o,
  output logic [31:0]    entry_length_o,
  output logic [31:0]    entry_type_o,
  output logic [6:0]     entry_count_o
);
  import pmsm_pkg::*;

  localparam int unsigned CW = $clog2(MaxSegments + 1);
  localparam int unsigned IW = $clog2(MaxSegments);
  localparam int unsigned PW = $clog2(MaxSegments + 2);

  // Round up to the configured minimum alignment
  function automatic logic [AddrW-1:0] round_up(input logic [AddrW-1:0] x,
                                                input logic [4:0] sh);
    logic [AddrW-1:0] m;
    m = ~({AddrW{1'b1}} << sh);
    return (x + m) & ~m;
  endfunction

  // Segment table
  seg_t seg_mem [MaxSegments];
  seg_t rd_q;
  logic          mem_we;
  logic [IW-1:0] mem_wa;
  logic [IW-1:0] mem_ra;
  seg_t          mem_wd;

  // Control registers
  logic [CW-1:0] cnt_q;
  logic [4:0]    align_q;
  logic          valid_q;

  // Request and working registers
  logic [1:0]       req_mode_q;
  logic [AddrW-1:0] req_addr_q, req_size_q, req_al_q;
  logic [KindW-1:0] req_tcode_q, req_ftype_q;
  logic [5:0]       req_eidx_q;
  logic [AddrW-1:0] a_q, s_q, end_q, pa_q, ra_q, rs_q;
  logic [AddrW-1:0] eb_q, el_q, ee_q;
  logic [KindW-1:0] ek_q;
  seg_t             ins_q, m_q;
  logic [CW-1:0]    ptr_q, pos_q, aidx_q;
  logic [PW-1:0]    pass_q;
  logic [1:0]       sr_st_q;
  logic [1:0]       res_status_q;
  logic [AddrW-1:0] res_addr_q;
  seg_t             res_ent_q;

  logic [AddrW-1:0] pa_calc;
  logic [CW:0]      cnt_ext, pos_ext;

  assign pa_calc = (rd_q.base + rd_q.len - req_size_q) & ~(req_al_q - AddrW'(1));
  assign cnt_ext = {1'b0, cnt_q};
  assign pos_ext = {1'b0, pos_q};

  // Status toward the controller
  always_comb begin
    sts_o.mode        = req_mode_q;
    sts_o.full        = cnt_q >= CW'(MaxSegments);
    sts_o.full2       = (cnt_ext + (CW+1)'(2)) > (CW+1)'(MaxSegments);
    sts_o.cnt_zero    = (cnt_q == '0);
    sts_o.al_bad      = (req_al_q == '0) || ((req_al_q & (req_al_q - AddrW'(1))) != '0);
    sts_o.eidx_ok     = 32'(req_eidx_q) < 32'(cnt_q);
    sts_o.ptr_eq_cnt  = (ptr_q == cnt_q);
    sts_o.ptr_eq_pos  = (ptr_q == pos_q);
    sts_o.rd_gt_a     = rd_q.base > a_q;
    sts_o.al_hit      = (aidx_q < cnt_q) && (rd_q.kind == req_ftype_q)
                        && (req_size_q <= rd_q.len);
    sts_o.aidx_zero   = (aidx_q == '0);
    sts_o.pass_over   = pass_q > PW'(MaxSegments);
    sts_o.sc_full     = (a_q >= eb_q) && (end_q <= ee_q);
    sts_o.sc_part     = (a_q >= eb_q) && (a_q < ee_q);
    sts_o.rt_whole    = (ra_q == eb_q) && (rs_q == el_q);
    sts_o.rt_head     = (ra_q == eb_q);
    sts_o.rt_tail     = ((ra_q + rs_q) == ee_q);
    sts_o.kind_diff   = (ek_q != req_tcode_q);
    sts_o.pos_ge_cnt  = pos_q >= cnt_q;
    sts_o.pos_zero    = (pos_q == '0);
    sts_o.pos1_ge_cnt = (pos_ext + (CW+1)'(1)) >= cnt_ext;
    sts_o.rdk_eq_mk   = (rd_q.kind == m_q.kind);
    sts_o.sr_st       = sr_st_q;
  end

  // Table read and write ports
  always_comb begin
    mem_we = 1'b0;
    mem_wa = IW'(pos_q);
    mem_wd = rd_q;
    mem_ra = IW'(ptr_q);
    unique case (cmd_i.op)
      OP_RD_PTR:   mem_ra = IW'(ptr_q);
      OP_RD_PTRM1: mem_ra = IW'(ptr_q - CW'(1));
      OP_RD_POS:   mem_ra = IW'(pos_q);
      OP_RD_POSM1: mem_ra = IW'(pos_q - CW'(1));
      OP_RD_POSP1: mem_ra = IW'(pos_q + CW'(1));
      OP_AL_RD:    mem_ra = IW'(aidx_q - CW'(1));
      OP_RD_EIDX:  mem_ra = IW'(req_eidx_q);
      OP_RT_WHOLE: begin
        mem_we = 1'b1;
        mem_wd = '{base: eb_q, len: el_q, kind: req_tcode_q};
      end
      OP_RT_HEAD: begin
        mem_we = 1'b1;
        mem_wd = '{base: eb_q + rs_q, len: el_q - rs_q, kind: ek_q};
      end
      OP_RT_TAIL: begin
        mem_we = 1'b1;
        mem_wd = '{base: eb_q, len: el_q - rs_q, kind: ek_q};
      end
      OP_RT_MID: begin
        mem_we = 1'b1;
        mem_wd = '{base: eb_q, len: ra_q - eb_q, kind: ek_q};
      end
      OP_MV_UP: begin
        mem_we = 1'b1;
        mem_wa = IW'(ptr_q);
      end
      OP_INS_WR: begin
        mem_we = 1'b1;
        mem_wd = ins_q;
      end
      OP_MRG_LW: begin
        mem_we = 1'b1;
        mem_wa = IW'(pos_q - CW'(1));
        mem_wd = '{base: rd_q.base, len: rd_q.len + m_q.len, kind: rd_q.kind};
      end
      OP_MRG_RW: begin
        mem_we = 1'b1;
        mem_wd = '{base: m_q.base, len: m_q.len + rd_q.len, kind: m_q.kind};
      end
      OP_ERS_MV: begin
        mem_we = 1'b1;
        mem_wa = IW'(ptr_q - CW'(1));
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      seg_mem[mem_wa] <= mem_wd;
    end
    rd_q <= seg_mem[mem_ra];
  end

  // Count, configuration and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      align_q <= '0;
      valid_q <= 1'b0;
    end else begin
      valid_q <= (cmd_i.op == OP_EMIT);
      if (cfg_valid_i) begin
        align_q <= cfg_data_i;
      end
      if (cmd_i.op == OP_INS_WR) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (cmd_i.op == OP_CNT_DEC) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LOAD: begin
        req_mode_q   <= mode_i;
        req_addr_q   <= address_i;
        req_size_q   <= size_i;
        req_tcode_q  <= type_code_i;
        req_ftype_q  <= from_type_i;
        req_al_q     <= alloc_align_i;
        req_eidx_q   <= entry_index_i;
        res_status_q <= STAT_OK;
        res_addr_q   <= '0;
        res_ent_q    <= '0;
      end
      OP_RES_ST: res_status_q <= cmd_i.code;
      OP_ADD_INIT: begin
        a_q   <= round_up(req_addr_q, align_q);
        s_q   <= round_up(req_size_q, align_q);
        ptr_q <= '0;
      end
      OP_PTR_INC: ptr_q <= ptr_q + CW'(1);
      OP_ADD_POS: begin
        pos_q <= ptr_q;
        ins_q <= '{base: a_q, len: s_q, kind: req_tcode_q};
      end
      OP_SET_INIT: begin
        a_q    <= req_addr_q;
        s_q    <= req_size_q;
        pass_q <= '0;
      end
      OP_SR_ST: sr_st_q <= cmd_i.code;
      OP_SR_ROUND: begin
        a_q    <= round_up(a_q, align_q);
        s_q    <= round_up(s_q, align_q);
        ptr_q  <= '0;
        pass_q <= pass_q + PW'(1);
      end
      OP_SR_END: end_q <= a_q + s_q;
      OP_LD_ENT: begin
        eb_q <= rd_q.base;
        el_q <= rd_q.len;
        ek_q <= rd_q.kind;
        ee_q <= rd_q.base + rd_q.len;
      end
      OP_SR_FULL: begin
        pos_q <= ptr_q;
        ra_q  <= a_q;
        rs_q  <= s_q;
      end
      OP_SR_PART: begin
        pos_q <= ptr_q;
        ra_q  <= a_q;
        rs_q  <= ee_q - a_q;
      end
      OP_SR_ADV: begin
        s_q <= s_q - rs_q;
        a_q <= ee_q;
      end
      OP_RT_WHOLE: sr_st_q <= STAT_OK;
      OP_RT_HEAD: begin
        ins_q   <= '{base: ra_q, len: rs_q, kind: req_tcode_q};
        sr_st_q <= STAT_OK;
      end
      OP_RT_TAIL, OP_RT_MID: begin
        ins_q   <= '{base: ra_q, len: rs_q, kind: req_tcode_q};
        pos_q   <= pos_q + CW'(1);
        sr_st_q <= STAT_OK;
      end
      OP_RT_MID2: begin
        ins_q <= '{base: ra_q + rs_q, len: el_q - rs_q - (ra_q - eb_q), kind: ek_q};
        pos_q <= pos_q + CW'(1);
      end
      OP_POS_DEC:  pos_q <= pos_q - CW'(1);
      OP_INS_INIT: ptr_q <= cnt_q;
      OP_MV_UP:    ptr_q <= ptr_q - CW'(1);
      OP_LD_M:     m_q <= rd_q;
      OP_MRG_LW: begin
        m_q.base <= rd_q.base;
        m_q.len  <= rd_q.len + m_q.len;
        ptr_q    <= pos_q + CW'(1);
        pos_q    <= pos_q - CW'(1);
      end
      OP_MRG_RW: begin
        m_q.len <= m_q.len + rd_q.len;
        ptr_q   <= pos_q + CW'(2);
      end
      OP_ERS_MV: ptr_q <= ptr_q + CW'(1);
      OP_AL_INIT: begin
        res_status_q <= STAT_MISS;
        aidx_q       <= cnt_q;
      end
      OP_AL_RD: aidx_q <= aidx_q - CW'(1);
      OP_AL_GO: begin
        a_q    <= pa_calc;
        pa_q   <= pa_calc;
        s_q    <= req_size_q;
        pass_q <= '0;
      end
      OP_AL_OK: begin
        res_status_q <= STAT_OK;
        res_addr_q   <= pa_q;
      end
      OP_FIN_SET: res_status_q <= sr_st_q;
      OP_RD_OUT:  res_ent_q <= rd_q;
      default: ;
    endcase
  end

  assign valid_o         = valid_q;
  assign status_o        = res_status_q;
  assign alloc_address_o = res_addr_q;
  assign entry_base_o    = res_ent_q.base;
  assign entry_length_o  = res_ent_q.len;
  assign entry_type_o    = res_ent_q.kind;
  assign entry_count_o   = 7'(cnt_q);

endmodule

// ===== rtl/physical_memory_segment_map.sv =====
// Memory segment map: a table of segments (base, length, type) kept in base
// order, with add, set-type, allocate and read requests.
// Request channel: drive the fields with start high; the transaction is
// taken at a clock edge where start is high and busy is low. busy then
// stays high until the request is finished.
// Result channel: valid_o is high for exactly one cycle with status_o,
// alloc_address_o, the entry_* fields and entry_count_o; the receiver must
// take it in that cycle, there is no back-pressure.
// Configuration: cfg_data_i sets log2 of the minimum alignment; cfg_ready_o
// is always high. Write it only while the block is idle.
// Sequence: a read loads the request, reads the entry, captures it and emits.
// An add scans for the first larger base, shifts entries up to insert, then
// merges, with up to two erase sweeps. A set retypes one segment per pass,
// each pass scanning the entries in turn and shifting the table on splits and
// merges; an allocate repeats that per candidate from the top entry down.
// Cost grows with the segment count, set by the table sweeps through one read
// port and one write port. Only one request is in flight at a time.
// Reset empties the table and clears the alignment to zero.
module physical_memory_segment_map #(
  parameter int unsigned MaxSegments = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode_i,
  input  logic [31:0] address_i,
  input  logic [31:0] size_i,
  input  logic [31:0] type_code_i,
  input  logic [31:0] from_type_i,
  input  logic [31:0] alloc_align_i,
  input  logic [5:0]  entry_index_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [4:0]  cfg_data_i,
  output logic        valid_o,
  output logic [1:0]  status_o,
  output logic [31:0] alloc_address_o,
  output logic [31:0] entry_base_o,
  output logic [31:0] entry_length_o,
  output logic [31:0] entry_type_o,
  output logic [6:0]  entry_count_o
);
  import pmsm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Configuration is always accepted
  assign cfg_ready_o = 1'b1;

  pmsm_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  pmsm_dp #(
    .MaxSegments (MaxSegments)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_valid_i     (cfg_valid_i && cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .mode_i          (mode_i),
    .address_i       (address_i),
    .size_i          (size_i),
    .type_code_i     (type_code_i),
    .from_type_i     (from_type_i),
    .alloc_align_i   (alloc_align_i),
    .entry_index_i   (entry_index_i),
    .valid_o         (valid_o),
    .status_o        (status_o),
    .alloc_address_o (alloc_address_o),
    .entry_base_o    (entry_base_o),
    .entry_length_o  (entry_length_o),
    .entry_type_o    (entry_type_o),
    .entry_count_o   (entry_count_o)
  );

  // An accepted transaction keeps the block busy until its result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  // A result appears only once the block has gone idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (!busy && !$past(valid_o)))
    else $error("result strobe while busy or repeated");

  // Entry count never exceeds table capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(entry_count_o) <= 32'(MaxSegments))
    else $error("entry count beyond capacity");

  // Nonzero entry data is returned only with an OK status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && (entry_base_o != '0)) |-> (status_o == STAT_OK))
    else $error("entry data returned with error status");

endmodule
